FILE: hdl/cell_rect_placement_table_defines.svh
// Assertion macros shared by the placement table RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef CELL_RECT_PLACEMENT_TABLE_DEFINES_SVH
`define CELL_RECT_PLACEMENT_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/crpt_pkg.sv
// Package for the cell rectangle placement table: sizes, codes and word types.
// No dependencies; every RTL module uses it by scoped names.
package crpt_pkg;

  localparam int SLOTS   = 64;
  localparam int ID_W    = 16;
  localparam int COORD_W = 12;
  localparam int ROW_W   = 16;
  localparam int OCC_W   = 7;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    KIND_PLACE  = 3'd0,
    KIND_LOOKUP = 3'd1,
    KIND_SCROLL = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_SIZE = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_MISS     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [ID_W-1:0]         img_id;
    logic signed [ROW_W-1:0] row;
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      width;
    logic [COORD_W-1:0]      height;
    logic signed [ROW_W-1:0] scroll_lines;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             hit;
    logic [ID_W-1:0]  hit_id;
    logic [OCC_W-1:0] occupied;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]         ident;
    logic signed [ROW_W-1:0] top;
    logic [COORD_W-1:0]      left;
    logic [COORD_W-1:0]      span_cols;
    logic [COORD_W-1:0]      span_rows;
  } slot_ent_t;

  typedef struct packed {
    logic                    id_match;
    logic                    covers;
    logic                    drops;
    logic signed [ROW_W-1:0] new_top;
  } eval_res_t;

  typedef struct packed {
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    slot_ent_t          wr_ent;
    logic               vld_set;
    logic               vld_clr;
    logic [SLOT_AW-1:0] clr_addr;
    logic               clr_all;
    logic [SLOT_AW-1:0] chk_addr;
  } store_ctl_t;

endpackage

FILE: hdl/crpt_slot_eval.sv
// Shared per-slot unit: id compare, cell cover test and saturating scroll.
// Depends on crpt_pkg.
module crpt_slot_eval (
  input  crpt_pkg::slot_ent_t ent,
  input  crpt_pkg::in_word_t  cmd,
  output crpt_pkg::eval_res_t res
);

  localparam int PAD_W = crpt_pkg::ROW_W + 1 - crpt_pkg::COORD_W;

  logic signed [crpt_pkg::ROW_W:0] row_x;
  logic signed [crpt_pkg::ROW_W:0] top_x;
  logic signed [crpt_pkg::ROW_W:0] lines_x;
  logic signed [crpt_pkg::ROW_W:0] span_x;
  logic signed [crpt_pkg::ROW_W:0] top_end;
  logic signed [crpt_pkg::ROW_W:0] diff;
  logic signed [crpt_pkg::ROW_W:0] end_x;
  logic [crpt_pkg::COORD_W:0]      col_end;
  logic signed [crpt_pkg::ROW_W-1:0] sat_top;
  logic row_ok;
  logic col_ok;

  always_comb begin
    row_x   = {cmd.row[crpt_pkg::ROW_W-1], cmd.row};
    top_x   = {ent.top[crpt_pkg::ROW_W-1], ent.top};
    lines_x = {cmd.scroll_lines[crpt_pkg::ROW_W-1], cmd.scroll_lines};
    span_x  = {{PAD_W{1'b0}}, ent.span_rows};

    // Cover test, computed one bit wider so the ends never wrap.
    top_end = top_x + span_x;
    row_ok  = (row_x >= top_x) && (row_x < top_end);
    col_end = {1'b0, ent.left} + {1'b0, ent.span_cols};
    col_ok  = (cmd.col >= ent.left) && ({1'b0, cmd.col} < col_end);

    // New top after a scroll, clamped to the signed row range.
    diff = top_x - lines_x;
    if (diff[crpt_pkg::ROW_W] != diff[crpt_pkg::ROW_W-1]) begin
      sat_top = diff[crpt_pkg::ROW_W] ? {1'b1, {(crpt_pkg::ROW_W-1){1'b0}}}
                                      : {1'b0, {(crpt_pkg::ROW_W-1){1'b1}}};
    end else begin
      sat_top = diff[crpt_pkg::ROW_W-1:0];
    end
    end_x = {sat_top[crpt_pkg::ROW_W-1], sat_top} + span_x;

    res.id_match = (ent.ident == cmd.img_id);
    res.covers   = row_ok && col_ok;
    res.new_top  = sat_top;
    res.drops    = end_x[crpt_pkg::ROW_W] || (end_x == '0);
  end

endmodule

FILE: hdl/crpt_slot_store.sv
// Slot storage: field memory with registered read, valid bits and occupancy count.
// Depends on crpt_pkg.
module crpt_slot_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  crpt_pkg::store_ctl_t         ctl,
  output crpt_pkg::slot_ent_t          rd_ent,
  output logic                         chk_valid,
  output logic [crpt_pkg::CNT_W-1:0]   occ
);

  crpt_pkg::slot_ent_t mem_r [crpt_pkg::SLOTS];
  crpt_pkg::slot_ent_t rd_ent_r;

  logic [crpt_pkg::SLOTS-1:0] vld_r;
  logic [crpt_pkg::SLOTS-1:0] vld_nxt;
  logic [crpt_pkg::CNT_W-1:0] occ_r;
  logic [crpt_pkg::CNT_W-1:0] occ_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[ctl.wr_addr] <= ctl.wr_ent;
    end
    if (ctl.rd_en) begin
      rd_ent_r <= mem_r[ctl.rd_addr];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    occ_nxt = occ_r;
    if (ctl.clr_all) begin
      vld_nxt = '0;
      occ_nxt = '0;
    end else begin
      if (ctl.vld_set && !vld_r[ctl.wr_addr]) begin
        vld_nxt[ctl.wr_addr] = 1'b1;
        occ_nxt = occ_nxt + crpt_pkg::CNT_W'(1);
      end
      if (ctl.vld_clr && vld_r[ctl.clr_addr]) begin
        vld_nxt[ctl.clr_addr] = 1'b0;
        if (occ_r != '0) begin
          occ_nxt = occ_nxt - crpt_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      occ_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      occ_r <= occ_nxt;
    end
  end

  assign rd_ent    = rd_ent_r;
  assign chk_valid = vld_r[ctl.chk_addr];
  assign occ       = occ_r;

endmodule

FILE: hdl/cell_rect_placement_table.sv
// Top level of the cell rectangle placement table: sequencer and output register.
// Depends on crpt_pkg, crpt_slot_store, crpt_slot_eval and the defines header.
//
//   Channel  Ports                          Word
//   input    in_valid / in_ready / in_data   crpt_pkg::in_word_t (one operation)
//   output   out_valid / out_ready / out_data crpt_pkg::out_word_t (one result)
//
// A place, lookup, remove or nonzero scroll is accepted, then reads the slots in turn
// through the single read port of the field memory, evaluates the last slot's read,
// sees the evaluation stage empty in the sweep, commits and loads the result.
// Clear, a zero-size place, a zero scroll and unused kinds skip the sweep.
// Reset clears the valid bits and the occupancy count directly, with no sweep.
// in_ready is high only while the sequencer is idle; a result waiting on out_ready
// holds the next operation in its final step, not at the input.
`include "cell_rect_placement_table_defines.svh"

module cell_rect_placement_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crpt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crpt_pkg::out_word_t out_data
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SWEEP  = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_RESP   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  crpt_pkg::in_word_t  cmd_r, cmd_nxt;
  logic [crpt_pkg::CNT_W-1:0]   iss_r, iss_nxt;
  logic                         ev_vld_r, ev_vld_nxt;
  logic [crpt_pkg::SLOT_AW-1:0] ev_idx_r, ev_idx_nxt;
  logic                         found_r, found_nxt;
  logic [crpt_pkg::SLOT_AW-1:0] found_idx_r, found_idx_nxt;
  logic                         free_found_r, free_found_nxt;
  logic [crpt_pkg::SLOT_AW-1:0] free_idx_r, free_idx_nxt;
  logic [crpt_pkg::ID_W-1:0]    hit_id_r, hit_id_nxt;
  crpt_pkg::status_t            status_r, status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  crpt_pkg::out_word_t          out_data_r, out_data_nxt;

  crpt_pkg::store_ctl_t       store_ctl;
  crpt_pkg::slot_ent_t        slot_rd;
  crpt_pkg::slot_ent_t        slot_upd;
  crpt_pkg::eval_res_t        eval_res;
  logic                       slot_vld;
  logic [crpt_pkg::CNT_W-1:0] occ;
  logic                       start_sweep;
  logic                       lookup_hit;

  crpt_slot_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (store_ctl),
    .rd_ent    (slot_rd),
    .chk_valid (slot_vld),
    .occ       (occ)
  );

  // The one evaluation unit sees the slot read in the previous cycle.
  crpt_slot_eval u_eval (
    .ent (slot_rd),
    .cmd (cmd_r),
    .res (eval_res)
  );

  // Operations that must walk the table; the rest go straight to commit.
  always_comb begin
    case (in_data.kind)
      crpt_pkg::KIND_PLACE:  start_sweep = (in_data.width != '0) && (in_data.height != '0);
      crpt_pkg::KIND_LOOKUP: start_sweep = 1'b1;
      crpt_pkg::KIND_SCROLL: start_sweep = (in_data.scroll_lines != '0);
      crpt_pkg::KIND_REMOVE: start_sweep = 1'b1;
      default:               start_sweep = 1'b0;
    endcase
  end

  always_comb begin
    slot_upd     = slot_rd;
    slot_upd.top = eval_res.new_top;
    lookup_hit   = (cmd_r.kind == crpt_pkg::KIND_LOOKUP) && found_r;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    iss_nxt        = iss_r;
    ev_vld_nxt     = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_id_nxt     = hit_id_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    store_ctl          = '0;
    store_ctl.chk_addr = ev_idx_r;
    store_ctl.wr_addr  = ev_idx_r;
    store_ctl.clr_addr = ev_idx_r;
    store_ctl.wr_ent   = slot_upd;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_data;
          iss_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          hit_id_nxt     = '0;
          state_nxt      = start_sweep ? ST_SWEEP : ST_COMMIT;
        end
      end

      ST_SWEEP: begin
        // Issue one read per cycle; the slot read last cycle is evaluated now.
        if (iss_r != crpt_pkg::CNT_W'(crpt_pkg::SLOTS)) begin
          store_ctl.rd_en   = 1'b1;
          store_ctl.rd_addr = iss_r[crpt_pkg::SLOT_AW-1:0];
          iss_nxt           = iss_r + crpt_pkg::CNT_W'(1);
          ev_vld_nxt        = 1'b1;
          ev_idx_nxt        = iss_r[crpt_pkg::SLOT_AW-1:0];
        end else if (!ev_vld_r) begin
          state_nxt = ST_COMMIT;
        end

        if (ev_vld_r) begin
          case (cmd_r.kind)
            crpt_pkg::KIND_PLACE: begin
              // A matching id anywhere beats the first free slot.
              if (slot_vld && eval_res.id_match && !found_r) begin
                found_nxt     = 1'b1;
                found_idx_nxt = ev_idx_r;
              end
              if (!slot_vld && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = ev_idx_r;
              end
            end
            crpt_pkg::KIND_LOOKUP: begin
              if (slot_vld && eval_res.covers && !found_r) begin
                found_nxt  = 1'b1;
                hit_id_nxt = slot_rd.ident;
              end
            end
            crpt_pkg::KIND_SCROLL: begin
              if (slot_vld) begin
                store_ctl.wr_en   = 1'b1;
                store_ctl.vld_clr = eval_res.drops;
              end
            end
            crpt_pkg::KIND_REMOVE: begin
              if (slot_vld && eval_res.id_match && !found_r) begin
                found_nxt         = 1'b1;
                store_ctl.vld_clr = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_COMMIT: begin
        status_nxt = crpt_pkg::STAT_OK;
        case (cmd_r.kind)
          crpt_pkg::KIND_PLACE: begin
            store_ctl.wr_ent.ident     = cmd_r.img_id;
            store_ctl.wr_ent.top       = cmd_r.row;
            store_ctl.wr_ent.left      = cmd_r.col;
            store_ctl.wr_ent.span_cols = cmd_r.width;
            store_ctl.wr_ent.span_rows = cmd_r.height;
            store_ctl.wr_addr          = found_r ? found_idx_r : free_idx_r;
            if ((cmd_r.width == '0) || (cmd_r.height == '0)) begin
              status_nxt = crpt_pkg::STAT_BAD_SIZE;
            end else if (found_r || free_found_r) begin
              store_ctl.wr_en   = 1'b1;
              store_ctl.vld_set = 1'b1;
            end else begin
              status_nxt = crpt_pkg::STAT_FULL;
            end
          end
          crpt_pkg::KIND_LOOKUP: begin
            status_nxt = found_r ? crpt_pkg::STAT_OK : crpt_pkg::STAT_MISS;
          end
          crpt_pkg::KIND_REMOVE: begin
            status_nxt = found_r ? crpt_pkg::STAT_OK : crpt_pkg::STAT_MISS;
          end
          crpt_pkg::KIND_CLEAR: begin
            store_ctl.clr_all = 1'b1;
          end
          default: begin
          end
        endcase
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // The count already reflects the commit of this operation.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = status_r;
          out_data_nxt.hit      = lookup_hit;
          out_data_nxt.hit_id   = lookup_hit ? hit_id_r : '0;
          out_data_nxt.occupied = crpt_pkg::OCC_W'(occ);
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    iss_r        <= iss_nxt;
    ev_idx_r     <= ev_idx_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_id_r     <= hit_id_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CRPT_ASSERT_SAME(a_occ_bound, 1'b1,
                    occ <= crpt_pkg::CNT_W'(crpt_pkg::SLOTS),
                    "occupancy above slot count")
  `CRPT_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != ST_IDLE,
                    "sequencer idle after accept")
  `CRPT_ASSERT_SAME(a_sweep_write, (state_r == ST_SWEEP) && store_ctl.wr_en,
                    cmd_r.kind == crpt_pkg::KIND_SCROLL,
                    "table write during a non-scroll sweep")
  `CRPT_ASSERT_SAME(a_clear_only, store_ctl.clr_all,
                    (state_r == ST_COMMIT) && (cmd_r.kind == crpt_pkg::KIND_CLEAR),
                    "clear outside a clear commit")
  `CRPT_ASSERT_NEXT(a_resp_load, (state_r == ST_RESP) && (!out_valid_r || out_ready),
                    out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for cell_rect_placement_table: a directed opening, then random
// operation streams with idle and stall bursts on both handshake sides.
// Depends on crpt_pkg and the cell_rect_placement_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crpt_pkg::*;

  // Even the slowest legal run of about 1700 words, with every sender gap and receiver
  // stall at its longest, stays far below this limit.
  localparam int CYCLE_LIMIT = 600_000;
  localparam int RANDOM_OPS  = 1600;
  localparam int SETTLE_CYCLES = 80;

  // Kind codes 5 to 7 are not assigned to any operation, and the block answers them
  // with a plain OK.
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  localparam int ROW_MAX = 32767;
  localparam int ROW_MIN = -32768;
  localparam int COL_MAX = 4095;

  // Scoreboard: it keeps a private copy of the slot table, works out the result of
  // every accepted operation and holds the results until the block returns them.
  class placement_scoreboard;
    bit              slot_live[SLOTS];
    logic [ID_W-1:0] slot_tag[SLOTS];
    int              slot_row0[SLOTS];
    int              slot_col0[SLOTS];
    int              slot_wd[SLOTS];
    int              slot_ht[SLOTS];
    int              live_count;
    out_word_t       pending_results[$];
    int              mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_tag[i]  = '0;
        slot_row0[i] = 0;
        slot_col0[i] = 0;
        slot_wd[i]   = 0;
        slot_ht[i]   = 0;
      end
      live_count = 0;
      mismatches = 0;
    endfunction

    function void release_slot(int i);
      slot_live[i] = 1'b0;
      if (live_count > 0) live_count--;
    endfunction

    // Applies one operation to the table copy and returns the result the block owes.
    function out_word_t apply_operation(in_word_t w);
      out_word_t r;
      int pick, row_i, col_i, lines_i, t;
      r       = '0;
      row_i   = int'($signed(w.row));
      col_i   = int'(w.col);
      lines_i = int'($signed(w.scroll_lines));
      case (w.kind)
        KIND_PLACE: begin
          // A zero-size placement is refused before the free-slot search.
          if (w.width == '0 || w.height == '0) begin
            r.status = STAT_BAD_SIZE;
          end else begin
            // A slot that already carries the id wins over the lowest free slot.
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_live[i] && slot_tag[i] == w.img_id) begin
                pick = i;
                break;
              end
              if (pick < 0 && !slot_live[i]) pick = i;
            end
            if (pick < 0) begin
              r.status = STAT_FULL;
            end else begin
              if (!slot_live[pick]) live_count++;
              slot_live[pick] = 1'b1;
              slot_tag[pick]  = w.img_id;
              slot_row0[pick] = row_i;
              slot_col0[pick] = col_i;
              slot_wd[pick]   = int'(w.width);
              slot_ht[pick]   = int'(w.height);
            end
          end
        end
        KIND_LOOKUP: begin
          // The cover bounds are 32-bit sums, so a rectangle near the top of the row
          // range or the right of the column range does not wrap around.
          r.status = STAT_MISS;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && row_i >= slot_row0[i] && row_i < slot_row0[i] + slot_ht[i]
                && col_i >= slot_col0[i] && col_i < slot_col0[i] + slot_wd[i]) begin
              r.status = STAT_OK;
              r.hit    = 1'b1;
              r.hit_id = slot_tag[i];
              break;
            end
          end
        end
        KIND_SCROLL: begin
          // A zero scroll leaves the table alone, even rectangles already above row 0.
          if (lines_i != 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_live[i]) begin
                t = slot_row0[i] - lines_i;
                if (t > ROW_MAX) t = ROW_MAX;
                if (t < ROW_MIN) t = ROW_MIN;
                slot_row0[i] = t;
                if (t + slot_ht[i] <= 0) release_slot(i);
              end
            end
          end
        end
        KIND_REMOVE: begin
          r.status = STAT_MISS;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && slot_tag[i] == w.img_id) begin
              release_slot(i);
              r.status = STAT_OK;
              break;
            end
          end
        end
        KIND_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
          live_count = 0;
        end
        default: begin
        end
      endcase
      r.occupied = live_count[OCC_W-1:0];
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending_results.push_back(apply_operation(w));
    endfunction

    function void report_field(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_field("status", 32'(want.status), 32'(got.status));
      if (got.hit !== want.hit)
        report_field("hit", 32'(want.hit), 32'(got.hit));
      if (got.hit_id !== want.hit_id)
        report_field("hit_id", 32'(want.hit_id), 32'(got.hit_id));
      if (got.occupied !== want.occupied)
        report_field("occupied", 32'(want.occupied), 32'(got.occupied));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Returns a random occupied slot, or -1 when the table is empty.
    function int pick_live_slot();
      int start;
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
        if (slot_live[(start + k) % SLOTS]) return (start + k) % SLOTS;
      end
      return -1;
    endfunction
  endclass

  // Every block input has a known value from time zero.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Idle and stall bursts are switched on and off in stretches by the stimulus.
  bit tx_idle_en  = 1'b0;
  bit rx_stall_en = 1'b0;
  int cycle_count = 0;

  placement_scoreboard sb = new();

  cell_rect_placement_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[cell_rect_placement_table] ERROR");
      $finish;
    end
  end

  // Both channels are observed at the clock edge, where the values read are the ones the
  // block itself sampled. The result is checked before the new word is noted, so a result
  // can never be matched against an operation accepted in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
    end
  end

  // Receiver: ready most of the time, with short stall bursts while stalls are enabled.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offers one word and returns at the edge where it is accepted. When no gap is taken,
  // valid simply stays high into the next word.
  task automatic send_op(input in_word_t w);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender back until every outstanding result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic in_word_t op_word(logic [2:0] kind, logic [15:0] id, int row, int col,
                                       int wd, int ht, int lines);
    in_word_t w;
    w.kind         = kind;
    w.img_id       = id;
    w.row          = 16'(row);
    w.col          = 12'(col);
    w.width        = 12'(wd);
    w.height       = 12'(ht);
    w.scroll_lines = 16'(lines);
    return w;
  endfunction

  // Random operation. Most fields stay small so that rectangles overlap, scroll off the
  // top and get hit by lookups; a share of full-range values reaches every field bit.
  // Lookups and removes are often aimed at a live rectangle taken from the scoreboard.
  function automatic in_word_t random_op(int id_span, int pct_place, int pct_lookup,
                                         int pct_scroll, int pct_remove, int pct_clear);
    in_word_t w;
    int roll, s, v;
    w = '0;
    w.img_id = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(0, id_span - 1));
    w.row = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80) - 40);
    w.col = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
    roll = $urandom_range(0, 19);
    w.width = (roll == 0) ? 12'd0 : (roll < 3) ? 12'($urandom) : 12'($urandom_range(1, 12));
    roll = $urandom_range(0, 19);
    w.height = (roll == 0) ? 12'd0 : (roll < 3) ? 12'($urandom) : 12'($urandom_range(1, 12));
    w.scroll_lines = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 12) - 6);
    roll = $urandom_range(0, 99);
    if (roll < pct_place) begin
      w.kind = KIND_PLACE;
    end else if (roll < pct_place + pct_lookup) begin
      w.kind = KIND_LOOKUP;
      s = sb.pick_live_slot();
      if (s >= 0 && $urandom_range(0, 9) < 6) begin
        // Aim inside the rectangle, or one past its far edge.
        v = sb.slot_row0[s] + $urandom_range(0, sb.slot_ht[s]);
        w.row = 16'((v > ROW_MAX) ? ROW_MAX : v);
        v = sb.slot_col0[s] + $urandom_range(0, sb.slot_wd[s]);
        w.col = 12'((v > COL_MAX) ? COL_MAX : v);
      end
    end else if (roll < pct_place + pct_lookup + pct_scroll) begin
      w.kind = KIND_SCROLL;
    end else if (roll < pct_place + pct_lookup + pct_scroll + pct_remove) begin
      w.kind = KIND_REMOVE;
      s = sb.pick_live_slot();
      if (s >= 0 && $urandom_range(0, 9) < 7) w.img_id = sb.slot_tag[s];
    end else if (roll < pct_place + pct_lookup + pct_scroll + pct_remove + pct_clear) begin
      w.kind = KIND_CLEAR;
    end else begin
      w.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end
    return w;
  endfunction

  initial begin
    int phase;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty-table misses, size rejects, rectangles at the corners of
    // the coordinate space, overwrite by id, scroll saturation and scroll-off freeing.
    send_op(op_word(KIND_LOOKUP, 16'd0, 0, 0, 0, 0, 0));
    send_op(op_word(KIND_REMOVE, 16'd5, 0, 0, 0, 0, 0));
    send_op(op_word(KIND_PLACE, 16'd1, 0, 0, 0, 5, 0));
    send_op(op_word(KIND_PLACE, 16'd1, 0, 0, 5, 0, 0));
    send_op(op_word(KIND_PLACE, 16'hFFFF, ROW_MIN, 0, COL_MAX, COL_MAX, 0));
    send_op(op_word(KIND_PLACE, 16'h0000, ROW_MAX, COL_MAX, COL_MAX, COL_MAX, 0));
    // Sums past the row and column limits must not wrap, so this is a hit on id 0.
    send_op(op_word(KIND_LOOKUP, 16'd0, ROW_MAX, COL_MAX, 0, 0, 0));
    // Last row and column inside the large rectangle, then just past its bottom edge
    // and just past its right edge.
    send_op(op_word(KIND_LOOKUP, 16'd0, ROW_MIN + COL_MAX - 1, COL_MAX - 1, 0, 0, 0));
    send_op(op_word(KIND_LOOKUP, 16'd0, ROW_MIN + COL_MAX, 0, 0, 0, 0));
    send_op(op_word(KIND_LOOKUP, 16'd0, ROW_MIN, COL_MAX, 0, 0, 0));
    // Same id again: the slot is reused and the count stays at two.
    send_op(op_word(KIND_PLACE, 16'hFFFF, 10, 10, 1, 1, 0));
    send_op(op_word(KIND_LOOKUP, 16'd0, 10, 10, 0, 0, 0));
    send_op(op_word(KIND_PLACE, 16'h1234, 0, 0, 1, 1, 0));
    send_op(op_word(KIND_SCROLL, 16'd0, 0, 0, 0, 0, 0));
    send_op(op_word(KIND_SCROLL, 16'd0, 0, 0, 0, 0, 1));
    send_op(op_word(KIND_SCROLL, 16'd0, 0, 0, 0, 0, ROW_MIN));
    send_op(op_word(KIND_SCROLL, 16'd0, 0, 0, 0, 0, ROW_MAX));
    send_op(op_word(KIND_SCROLL, 16'd0, 0, 0, 0, 0, ROW_MAX));
    // Saturation at the bottom of the row range, with the rectangle dropped.
    send_op(op_word(KIND_PLACE, 16'd7, ROW_MIN, 5, 5, 5, 0));
    send_op(op_word(KIND_SCROLL, 16'd0, 0, 0, 0, 0, 1));
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_op(op_word(3'(k), 16'd3, 1, 1, 1, 1, 1));
    end
    send_op(op_word(KIND_PLACE, 16'd3, 0, 0, 2, 2, 0));
    send_op(op_word(KIND_REMOVE, 16'd3, 0, 0, 0, 0, 0));
    send_op(op_word(KIND_REMOVE, 16'd3, 0, 0, 0, 0, 0));
    send_op(op_word(KIND_PLACE, 16'd9, 4, 4, 3, 3, 0));
    send_op(op_word(KIND_CLEAR, 16'd0, 0, 0, 0, 0, 0));
    wait_for_drain();

    // Fill the table past its capacity: the last two distinct ids find it full, while
    // an id already present can still be moved.
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    for (int k = 0; k < SLOTS + 2; k++) begin
      send_op(op_word(KIND_PLACE, 16'h4000 + 16'(k), k, k, 3, 3, 0));
    end
    send_op(op_word(KIND_PLACE, 16'h4000, 100, 100, 2, 2, 0));
    send_op(op_word(KIND_LOOKUP, 16'd0, 101, 101, 0, 0, 0));
    send_op(op_word(KIND_SCROLL, 16'd0, 0, 0, 0, 0, 20));

    // Random part in four phases: a small id pool with many hits, a large pool that runs
    // the table full, a middle mix, and a last phase with no idling at all.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      phase = n / (RANDOM_OPS / 4);
      if (n % 50 == 0) begin
        tx_idle_en  = (phase != 3) && ($urandom_range(0, 3) != 0);
        rx_stall_en = (phase != 3) && ($urandom_range(0, 3) != 0);
      end
      if (n % 250 == 0) wait_for_drain();
      case (phase)
        0:       send_op(random_op(16, 35, 35, 10, 12, 3));
        1:       send_op(random_op(200, 60, 25, 8, 5, 1));
        2:       send_op(random_op(40, 45, 30, 10, 10, 2));
        default: send_op(random_op(16, 35, 35, 10, 12, 3));
      endcase
    end

    // Let the last results come back, then give the block time for anything stray.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[cell_rect_placement_table] OK");
    end else begin
      $display("[cell_rect_placement_table] ERROR");
    end
    $finish;
  end

endmodule
